[hw/rtl/adaptive_threshold_step_detector_core_defines.svh]
// ----------------------------------------------------------------------------
// adaptive threshold step detector: assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_THRESHOLD_STEP_DETECTOR_CORE_DEFINES_SVH
`define ADAPTIVE_THRESHOLD_STEP_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication
`define ATSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ATSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/atsd_pkg.sv]
// ----------------------------------------------------------------------------
// atsd_pkg
// widths, register indexes, reset values and helpers of the step detector
// ----------------------------------------------------------------------------
package atsd_pkg;

    localparam int ACC_W      = 16;
    localparam int SUM_W      = 32;
    localparam int ROOT_W     = 16;
    localparam int LVL_W      = 16;
    localparam int WIN_W      = 17;
    localparam int CNT_W      = 8;
    localparam int TIME_W     = 32;
    localparam int TOT_W      = 32;
    localparam int HYST_W     = 10;
    localparam int INC_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FILT_W     = 20;
    localparam int MUL_W      = 21;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int RECIP_SH   = 23;

    // ceil(2^23 / 10), exact floor(n / 10) for n below 2^20
    localparam logic [MUL_W-1:0] RECIP_TEN = 21'd838861;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_THRESHOLD   = 3'd0,
        CFG_MIN_INTERVAL    = 3'd1,
        CFG_WINDOW_LEN      = 3'd2,
        CFG_HYSTERESIS_HALF = 3'd3,
        CFG_STRIDE_MM       = 3'd4,
        CFG_ENERGY_PER_STEP = 3'd5,
        CFG_REST_LEVEL      = 3'd6
    } cfg_idx_t;

    localparam logic [LVL_W-1:0]  RST_MIN_THRESHOLD = 16'd2688;
    localparam logic [15:0]       RST_MIN_INTERVAL  = 16'd200;
    localparam logic [CNT_W-1:0]  RST_WINDOW_LEN    = 8'd50;
    localparam logic [HYST_W-1:0] RST_HYSTERESIS    = 10'd128;
    localparam logic [INC_W-1:0]  RST_STRIDE_MM     = 12'd750;
    localparam logic [INC_W-1:0]  RST_ENERGY_STEP   = 12'd40;
    localparam logic [LVL_W-1:0]  RST_REST_LEVEL    = 16'd2511;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SQUARE = 8'b0000_0010,
        ST_ROOT   = 8'b0000_0100,
        ST_DIV    = 8'b0000_1000,
        ST_WIN    = 8'b0001_0000,
        ST_THR    = 8'b0010_0000,
        ST_STEP   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

endpackage

[hw/rtl/adaptive_threshold_step_detector_core.sv]
// ----------------------------------------------------------------------------
// adaptive_threshold_step_detector_core
// accelerometer pedometer: magnitude, smoothing, adaptive threshold, step count
// ----------------------------------------------------------------------------
// sequence: a sample transaction passes through three squaring passes, the
//   square root loop, the divide, window, threshold and step passes and the
//   result load; a clear transaction goes straight to the result load
// flow: one transaction at a time; a new one is taken only in idle, after
//   the result register has taken the result of the one before
// reset: rst_n asynchronous, active low; registers return to their defaults,
//   tracker and counters to their cleared values, no result pending
// ----------------------------------------------------------------------------
module adaptive_threshold_step_detector_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [atsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [atsd_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic signed [atsd_pkg::ACC_W-1:0] accel_x,
    input  logic signed [atsd_pkg::ACC_W-1:0] accel_y,
    input  logic signed [atsd_pkg::ACC_W-1:0] accel_z,
    input  logic [atsd_pkg::TIME_W-1:0]     time_ms,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            step_detected,
    output logic [atsd_pkg::TOT_W-1:0]      step_total,
    output logic [atsd_pkg::TOT_W-1:0]      distance_mm,
    output logic [atsd_pkg::TOT_W-1:0]      energy_total,
    output logic [atsd_pkg::LVL_W-1:0]      filtered_level,
    output logic [atsd_pkg::LVL_W-1:0]      threshold_level
);
    import atsd_pkg::*;

    // configuration registers
    logic [LVL_W-1:0]  min_thr_reg;
    logic [15:0]       min_int_reg;
    logic [CNT_W-1:0]  win_len_reg;
    logic [HYST_W-1:0] hyst_reg;
    logic [INC_W-1:0]  stride_reg;
    logic [INC_W-1:0]  energy_inc_reg;
    logic [LVL_W-1:0]  rest_reg;

    // sequencer
    state_t      state_reg, state_next;
    logic [1:0]  axis_reg,  axis_next;
    logic        start_reg, start_next;
    logic        accept;

    // latched transaction payload
    logic signed [ACC_W-1:0] ax_reg, ay_reg, az_reg;
    logic [TIME_W-1:0]       time_reg;

    // datapath scratch
    logic [SUM_W-1:0]  sum_reg,  sum_next;
    logic [FILT_W-1:0] filt_reg, filt_next;

    // tracker state
    logic [LVL_W-1:0]  smooth_reg, smooth_next;
    logic [WIN_W-1:0]  wmax_reg,   wmax_next;
    logic [WIN_W-1:0]  wmin_reg,   wmin_next;
    logic [LVL_W-1:0]  thr_reg,    thr_next;
    logic [CNT_W-1:0]  wcnt_reg,   wcnt_next;
    logic              above_reg,  above_next;
    logic [TIME_W-1:0] last_reg,   last_next;
    logic [TOT_W-1:0]  steps_reg,  steps_next;
    logic [TOT_W-1:0]  dist_reg,   dist_next;
    logic [TOT_W-1:0]  energy_reg, energy_next;
    logic              det_reg,    det_next;

    // result register
    logic              ovalid_reg, ovalid_next;
    logic              odet_reg;
    logic [TOT_W-1:0]  osteps_reg, odist_reg, oenergy_reg;
    logic [LVL_W-1:0]  ofilt_reg,  othr_reg;
    logic              oload;

    // shared multiplier: squares of the axes, then the divide by ten
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  axis_val;

    // square root unit
    logic             root_done;
    logic [ROOT_W-1:0] root_val;

    // threshold adaptation
    logic [WIN_W:0]    mid_sum;
    logic [WIN_W-1:0]  mid_raw;
    logic [LVL_W-1:0]  mid_sat;
    logic [LVL_W-1:0]  mid_thr;

    // step qualification
    logic [TIME_W-1:0] elapsed;
    logic              step_hit;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_thr_reg    <= RST_MIN_THRESHOLD;
            min_int_reg    <= RST_MIN_INTERVAL;
            win_len_reg    <= RST_WINDOW_LEN;
            hyst_reg       <= RST_HYSTERESIS;
            stride_reg     <= RST_STRIDE_MM;
            energy_inc_reg <= RST_ENERGY_STEP;
            rest_reg       <= RST_REST_LEVEL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_THRESHOLD:   min_thr_reg    <= cfg_data;
                CFG_MIN_INTERVAL:    min_int_reg    <= cfg_data;
                CFG_WINDOW_LEN:      win_len_reg    <= cfg_data[CNT_W-1:0];
                CFG_HYSTERESIS_HALF: hyst_reg       <= cfg_data[HYST_W-1:0];
                CFG_STRIDE_MM:       stride_reg     <= cfg_data[INC_W-1:0];
                CFG_ENERGY_PER_STEP: energy_inc_reg <= cfg_data[INC_W-1:0];
                CFG_REST_LEVEL:      rest_reg       <= cfg_data;
                default:             ;
            endcase
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        case (axis_reg)
            2'd0:    axis_val = ax_reg;
            2'd1:    axis_val = ay_reg;
            default: axis_val = az_reg;
        endcase
    end

    // a square in the squaring pass, the filter sum times 1/10 otherwise
    assign mul_a = (state_reg == ST_DIV) ? $signed({1'b0, filt_reg})
                                         : MUL_W'(axis_val);
    assign prod  = (state_reg == ST_DIV) ? mul_a * $signed(RECIP_TEN)
                                         : mul_a * mul_a;

    // ---------------- square root ----------------
    atsd_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .operand (sum_reg),
        .done    (root_done),
        .root    (root_val)
    );

    // ---------------- threshold adaptation terms ----------------
    assign mid_sum = {1'b0, wmax_reg} + {1'b0, wmin_reg};
    assign mid_raw = mid_sum[WIN_W:1];
    // mid-range saturates at full scale, then clamps at the floor register
    assign mid_sat = mid_raw[WIN_W-1] ? {LVL_W{1'b1}} : mid_raw[LVL_W-1:0];
    assign mid_thr = (mid_sat < min_thr_reg) ? min_thr_reg : mid_sat;

    // ---------------- step terms ----------------
    assign elapsed  = time_reg - last_reg;    // wraps with the time base
    assign step_hit = !above_reg && (smooth_reg > thr_reg)
                      && (elapsed >= {{(TIME_W-16){1'b0}}, min_int_reg});

    // result register frees when empty or taken this cycle
    assign oload = (state_reg == ST_DONE) && (!ovalid_reg || out_ready);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        start_next  = 1'b0;
        sum_next    = sum_reg;
        filt_next   = filt_reg;
        smooth_next = smooth_reg;
        wmax_next   = wmax_reg;
        wmin_next   = wmin_reg;
        thr_next    = thr_reg;
        wcnt_next   = wcnt_reg;
        above_next  = above_reg;
        last_next   = last_reg;
        steps_next  = steps_reg;
        dist_next   = dist_reg;
        energy_next = energy_reg;
        det_next    = det_reg;
        ovalid_next = ovalid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func)
                    begin
                        // clear transaction: back to the reset picture
                        smooth_next = rest_reg;
                        wmax_next   = {1'b0, rest_reg};
                        wmin_next   = {1'b0, rest_reg};
                        thr_next    = min_thr_reg;
                        wcnt_next   = '0;
                        above_next  = 1'b0;
                        last_next   = '0;
                        steps_next  = '0;
                        dist_next   = '0;
                        energy_next = '0;
                        det_next    = 1'b0;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        axis_next  = 2'd0;
                        sum_next   = '0;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE:
            begin
                // squares are non-negative and three of them fit in 32 bits
                sum_next  = sum_reg + prod[SUM_W-1:0];
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd2)
                begin
                    start_next = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    // 9 * level + magnitude
                    filt_next  = {1'b0, smooth_reg, 3'b000} + {4'b0000, smooth_reg}
                               + {4'b0000, root_val};
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                smooth_next = prod[RECIP_SH+LVL_W-1:RECIP_SH];
                state_next  = ST_WIN;
            end
            ST_WIN:
            begin
                if ({1'b0, smooth_reg} > wmax_reg)
                begin
                    wmax_next = {1'b0, smooth_reg};
                end
                if ({1'b0, smooth_reg} < wmin_reg)
                begin
                    wmin_next = {1'b0, smooth_reg};
                end
                wcnt_next  = wcnt_reg + 8'd1;
                state_next = ST_THR;
            end
            ST_THR:
            begin
                // window complete (a zero length adapts every sample)
                if (wcnt_reg >= win_len_reg)
                begin
                    thr_next  = mid_thr;
                    wmax_next = {1'b0, mid_thr} + {7'b0, hyst_reg};
                    wmin_next = (mid_thr >= {6'b0, hyst_reg})
                              ? {1'b0, mid_thr - {6'b0, hyst_reg}} : '0;
                    wcnt_next = '0;
                end
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                det_next = step_hit;
                if (step_hit)
                begin
                    steps_next  = sat_add(steps_reg, 32'd1);
                    dist_next   = sat_add(dist_reg, {20'b0, stride_reg});
                    energy_next = sat_add(energy_reg, {20'b0, energy_inc_reg});
                    last_next   = time_reg;
                    above_next  = 1'b1;
                end
                // equal to the threshold keeps the armed state
                if (smooth_reg < thr_reg)
                begin
                    above_next = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (oload)
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            axis_reg   <= '0;
            start_reg  <= 1'b0;
            smooth_reg <= RST_REST_LEVEL;
            wmax_reg   <= {1'b0, RST_REST_LEVEL};
            wmin_reg   <= {1'b0, RST_REST_LEVEL};
            thr_reg    <= RST_MIN_THRESHOLD;
            wcnt_reg   <= '0;
            above_reg  <= 1'b0;
            last_reg   <= '0;
            steps_reg  <= '0;
            dist_reg   <= '0;
            energy_reg <= '0;
            det_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            start_reg  <= start_next;
            smooth_reg <= smooth_next;
            wmax_reg   <= wmax_next;
            wmin_reg   <= wmin_next;
            thr_reg    <= thr_next;
            wcnt_reg   <= wcnt_next;
            above_reg  <= above_next;
            last_reg   <= last_next;
            steps_reg  <= steps_next;
            dist_reg   <= dist_next;
            energy_reg <= energy_next;
            det_reg    <= det_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        filt_reg <= filt_next;
        if (accept)
        begin
            ax_reg   <= accel_x;
            ay_reg   <= accel_y;
            az_reg   <= accel_z;
            time_reg <= time_ms;
        end
        if (oload)
        begin
            odet_reg    <= det_reg;
            osteps_reg  <= steps_reg;
            odist_reg   <= dist_reg;
            oenergy_reg <= energy_reg;
            ofilt_reg   <= smooth_reg;
            othr_reg    <= thr_reg;
        end
    end

    assign out_valid       = ovalid_reg;
    assign step_detected   = odet_reg;
    assign step_total      = osteps_reg;
    assign distance_mm     = odist_reg;
    assign energy_total    = oenergy_reg;
    assign filtered_level  = ofilt_reg;
    assign threshold_level = othr_reg;

endmodule

[hw/rtl/atsd_isqrt.sv]
// ----------------------------------------------------------------------------
// atsd_isqrt
// bit-pair iterative floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module atsd_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [atsd_pkg::SUM_W-1:0]  operand,
    output logic                        done,
    output logic [atsd_pkg::ROOT_W-1:0] root
);
    import atsd_pkg::*;

    localparam logic [SUM_W-2:0] BIT_INIT = {1'b1, {(SUM_W-2){1'b0}}};

    logic [SUM_W-1:0] rem_reg,  rem_next;
    logic [SUM_W-1:0] root_reg, root_next;
    logic [SUM_W-2:0] bit_reg,  bit_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SUM_W:0]   trial;
    logic             fits;

    assign trial = {1'b0, root_reg} + {2'b00, bit_reg};
    assign fits  = ({1'b0, rem_reg} >= trial);

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = operand;
            root_next = '0;
            bit_next  = BIT_INIT;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next  = rem_reg - trial[SUM_W-1:0];
                root_next = (root_reg >> 1) + {1'b0, bit_reg};
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            // last bit pair
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign root = root_reg[ROOT_W-1:0];

endmodule

[hw/rtl/atsd_checker.sv]
// ----------------------------------------------------------------------------
// atsd_checker
// port-level checks of the step detector, bound to the top level
// ----------------------------------------------------------------------------
`include "adaptive_threshold_step_detector_core_defines.svh"

module atsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        step_detected,
    input logic [31:0] step_total,
    input logic [15:0] filtered_level,
    input logic [15:0] threshold_level
);

    // one transaction in flight at a time
    `ATSD_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // a counted step always leaves a nonzero total
    `ATSD_ASSERT_NOW(a_step_has_total, out_valid && step_detected, step_total != 32'd0, "step with zero total")

    // stalled result stays offered
    `ATSD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // stalled result keeps its payload
    `ATSD_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(step_total) && $stable(filtered_level) && $stable(threshold_level) && $stable(step_detected), "result changed while stalled")

endmodule

bind adaptive_threshold_step_detector_core atsd_checker u_atsd_checker (.*);
